>>> src/cfc_pkg.sv
// ----------------------------------------------------------------------------
// cfc_pkg
// Types and constants shared by the compressor fill controller.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int RETRY_BITS  = 16;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 3;

  // Pressure constants, in converter counts
  localparam logic [RETRY_BITS-1:0] REARM_GAP   = 16'd200;
  localparam logic [RETRY_BITS-1:0] BAR3_COUNTS = 16'd2400;
  localparam logic [RETRY_BITS-1:0] BAR2_COUNTS = 16'd1500;
  localparam logic [RETRY_BITS-1:0] BAR1_COUNTS = 16'd780;

  // Controller states
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_FILLING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_FAULT   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_LP_UNDER  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LP_OVER   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HP_OVER   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HP_SENSOR = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HP_FULL   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_RETRY     = 3'd5;

  // Fault flag bit positions
  localparam int FLAG_LP_UNDER  = 0;
  localparam int FLAG_LP_OVER   = 1;
  localparam int FLAG_HP_OVER   = 2;
  localparam int FLAG_HP_SENSOR = 3;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] lp_sample;
    logic [SAMPLE_BITS-1:0] hp_sample;
  } cfc_in_t;

  typedef struct packed {
    logic [1:0] ctrl_state;
    logic [3:0] fault_flags;
    logic       compressor_on;
    logic       green_lamp;
    logic       amber_lamp;
    logic       led_red;
    logic [2:0] bar_level;
  } cfc_out_t;

endpackage

>>> src/compressor_fill_controller.sv
// ----------------------------------------------------------------------------
// compressor_fill_controller
// Tank fill state machine driven by one pair of pressure samples per tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one control tick (low- and high-pressure sample).
//   out_valid/out_ready carry the status for that tick: state, fault flags,
//   compressor enable, three lamps and the bar graph level.
//   The status is registered: a tick transferred at an edge has its status
//   in the output register after that edge. One tick per cycle is sustained
//   while out_ready holds; the state update and all compares are combinational.
//   When the receiver stalls, the output register holds its status and
//   in_ready drops until it is taken; a tick can enter in the same cycle
//   the held status is transferred.
//   Reset returns the state to idle, clears the retry counter, switches the
//   compressor off, empties the output register and loads the default
//   thresholds. Configuration writes via cfg_wr_en/cfg_index/cfg_data take
//   effect at the next edge; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module compressor_fill_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cfc_pkg::cfc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cfc_pkg::cfc_out_t                 out_data,
  input  logic                              cfg_wr_en,
  input  logic [cfc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [cfc_pkg::CFG_BITS-1:0]      cfg_data
);
  import cfc_pkg::*;

  logic [SAMPLE_BITS-1:0] lp_under_threshold;
  logic [SAMPLE_BITS-1:0] lp_over_threshold;
  logic [SAMPLE_BITS-1:0] hp_over_threshold;
  logic [SAMPLE_BITS-1:0] hp_sensor_threshold;
  logic [SAMPLE_BITS-1:0] hp_full_threshold;
  logic [RETRY_BITS-1:0]  fault_retry_ticks;

  logic [1:0]            mode_reg, mode_reg_next;
  logic [RETRY_BITS-1:0] retry_counter, retry_counter_next;
  logic                  compressor_reg, compressor_reg_next;

  logic [RETRY_BITS-1:0] retry_inc;
  logic [RETRY_BITS-1:0] hp_wide;
  logic [RETRY_BITS-1:0] full_wide;
  logic                  hp_full;
  logic                  below_rearm;
  logic [3:0]            flags;
  logic [2:0]            bar;
  logic                  accept;
  cfc_out_t              result;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lp_under_threshold  <= SAMPLE_BITS'(100);
      lp_over_threshold   <= SAMPLE_BITS'(3900);
      hp_over_threshold   <= SAMPLE_BITS'(4000);
      hp_sensor_threshold <= SAMPLE_BITS'(50);
      hp_full_threshold   <= SAMPLE_BITS'(3000);
      fault_retry_ticks   <= RETRY_BITS'(100);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LP_UNDER:  lp_under_threshold  <= cfg_data[SAMPLE_BITS-1:0];
        REG_LP_OVER:   lp_over_threshold   <= cfg_data[SAMPLE_BITS-1:0];
        REG_HP_OVER:   hp_over_threshold   <= cfg_data[SAMPLE_BITS-1:0];
        REG_HP_SENSOR: hp_sensor_threshold <= cfg_data[SAMPLE_BITS-1:0];
        REG_HP_FULL:   hp_full_threshold   <= cfg_data[SAMPLE_BITS-1:0];
        REG_RETRY:     fault_retry_ticks   <= cfg_data[RETRY_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hp_wide   = RETRY_BITS'(in_data.hp_sample);
    full_wide = RETRY_BITS'(hp_full_threshold);

    flags[FLAG_LP_UNDER]  = in_data.lp_sample < lp_under_threshold;
    flags[FLAG_LP_OVER]   = in_data.lp_sample > lp_over_threshold;
    flags[FLAG_HP_OVER]   = in_data.hp_sample > hp_over_threshold;
    flags[FLAG_HP_SENSOR] = in_data.hp_sample < hp_sensor_threshold;

    hp_full = in_data.hp_sample >= hp_full_threshold;
    // A full threshold under the gap has a negative re-arm point: never below
    below_rearm = (full_wide >= REARM_GAP) && ((hp_wide + REARM_GAP) < full_wide);

    if (retry_counter == {RETRY_BITS{1'b1}}) begin
      retry_inc = retry_counter;
    end else begin
      retry_inc = retry_counter + RETRY_BITS'(1);
    end

    mode_reg_next       = mode_reg;
    retry_counter_next  = retry_counter;
    compressor_reg_next = compressor_reg;

    if (flags != 4'd0) begin
      mode_reg_next       = ST_FAULT;
      retry_counter_next  = '0;
      compressor_reg_next = 1'b0;
    end else begin
      case (mode_reg)
        ST_IDLE: begin
          if (hp_full) begin
            mode_reg_next = ST_FULL;
          end else begin
            mode_reg_next       = ST_FILLING;
            compressor_reg_next = 1'b1;
          end
        end
        ST_FILLING: begin
          if (hp_full) begin
            mode_reg_next       = ST_FULL;
            compressor_reg_next = 1'b0;
          end
        end
        ST_FULL: begin
          if (below_rearm) begin
            mode_reg_next = ST_IDLE;
          end
        end
        default: begin
          retry_counter_next = retry_inc;
          if (retry_inc >= fault_retry_ticks) begin
            mode_reg_next = ST_IDLE;
          end
        end
      endcase
    end

    if (!below_rearm) begin
      bar = 3'd4;
    end else if (hp_wide >= BAR3_COUNTS) begin
      bar = 3'd3;
    end else if (hp_wide >= BAR2_COUNTS) begin
      bar = 3'd2;
    end else if (hp_wide >= BAR1_COUNTS) begin
      bar = 3'd1;
    end else begin
      bar = 3'd0;
    end

    result.ctrl_state    = mode_reg_next;
    result.fault_flags   = flags;
    result.compressor_on = compressor_reg_next;
    result.green_lamp    = (mode_reg_next == ST_FILLING) || (mode_reg_next == ST_FULL);
    result.amber_lamp    = (mode_reg_next == ST_IDLE) || (mode_reg_next == ST_FILLING);
    result.led_red       = mode_reg_next == ST_FAULT;
    result.bar_level     = bar;
  end

  // Advance state on each tick transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= ST_IDLE;
      retry_counter  <= '0;
      compressor_reg <= 1'b0;
    end else if (accept) begin
      mode_reg       <= mode_reg_next;
      retry_counter  <= retry_counter_next;
      compressor_reg <= compressor_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  a_fault_forces_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.fault_flags != 4'd0)) |->
      (out_data.ctrl_state == ST_FAULT && !out_data.compressor_on))
    else $error("fault flags without fault state");

  a_compressor_only_filling: assert property (@(posedge clk) disable iff (rst)
    compressor_reg == (mode_reg == ST_FILLING))
    else $error("compressor enable does not match filling state");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && mode_reg == ST_IDLE && retry_counter == '0))
    else $error("reset did not clear control state");

endmodule
